@@ rtl/keypad_event_queue_unit_macros.svh @@
// assertion helpers shared by the rtl files
`ifndef KEYPAD_EVENT_QUEUE_UNIT_MACROS_SVH
`define KEYPAD_EVENT_QUEUE_UNIT_MACROS_SVH

// generic form with explicit clock and active-low reset
`define KPQ_ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// form bound to the block clock and reset
`define KPQ_ASSERT(label, prop, msg) `KPQ_ASSERT_CLK(label, clk_i, rst_ni, prop, msg)

`endif

@@ rtl/kpq_pkg.sv @@
package kpq_pkg;

  // event fifo depth default, one slot stays empty
  localparam int unsigned KPQ_QUEUE_DEPTH = 32;

  // chord hold time in ms
  localparam logic [31:0] KPQ_HOLD_MS = 32'd600;

  // command queue between front and back
  localparam int unsigned KPQ_CMDQ_PTR_W = 2;
  localparam int unsigned KPQ_CMDQ_DEPTH = 1 << KPQ_CMDQ_PTR_W;

  localparam int unsigned KPQ_REG_IDX_W = 3;

  typedef enum logic [1:0] {
    OP_SCAN   = 2'd0,
    OP_SERIAL = 2'd1,
    OP_PUSH   = 2'd2,
    OP_POP    = 2'd3
  } kpq_op_e;

  typedef enum logic [2:0] {
    REG_ENTER  = 3'd0,
    REG_ESCAPE = 3'd1,
    REG_UP     = 3'd2,
    REG_DOWN   = 3'd3,
    REG_LEFT   = 3'd4,
    REG_RIGHT  = 3'd5,
    REG_USE    = 3'd6,
    REG_FIRE   = 3'd7
  } kpq_reg_e;

  localparam logic [5:0] CHORD_LANDSCAPE = 6'b011000;
  localparam logic [5:0] CHORD_PORTRAIT  = 6'b101000;

  typedef struct packed {
    logic [1:0]  op;
    logic [5:0]  keys_down;
    logic        portrait;
    logic [31:0] now_ms;
    logic [7:0]  key_byte;
    logic        push_pressed;
  } kpq_item_t;

  typedef struct packed {
    logic       event_valid;
    logic       event_pressed;
    logic [7:0] event_key;
    logic       pitch_toggle;
    logic [4:0] queue_count;
  } kpq_result_t;

  typedef struct packed {
    logic [7:0] code_enter;
    logic [7:0] code_escape;
    logic [7:0] code_up;
    logic [7:0] code_down;
    logic [7:0] code_left;
    logic [7:0] code_right;
    logic [7:0] code_use;
    logic [7:0] code_fire;
  } kpq_codes_t;

  localparam kpq_codes_t KPQ_CODES_RESET = '{
    code_enter:  8'd13,
    code_escape: 8'd27,
    code_up:     8'd173,
    code_down:   8'd175,
    code_left:   8'd172,
    code_right:  8'd174,
    code_use:    8'd162,
    code_fire:   8'd163
  };

  // front to back command: an event push or the end marker of one item
  typedef struct packed {
    logic       is_end;
    logic       pressed;
    logic [7:0] key;
    logic       pop;
    logic       pulse;
  } kpq_cmd_t;

endpackage

@@ rtl/kpq_item_if.sv @@
interface kpq_item_if import kpq_pkg::*; ();
  logic      valid;
  logic      ready;
  kpq_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/kpq_result_if.sv @@
interface kpq_result_if import kpq_pkg::*; ();
  logic        valid;
  logic        ready;
  kpq_result_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/kpq_front.sv @@
`include "keypad_event_queue_unit_macros.svh"

module kpq_front import kpq_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  kpq_item_if.sink                 item_i,
  input  logic                     cfg_valid_i,
  input  logic [KPQ_REG_IDX_W-1:0] cfg_index_i,
  input  logic [7:0]               cfg_data_i,
  output logic                     cfg_ready_o,
  output kpq_cmd_t                 cmd_o,
  output logic                     cmd_valid_o,
  input  logic                     cmd_ready_i
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_REL  = 3'd1;
  localparam logic [2:0] ST_CHG  = 3'd2;
  localparam logic [2:0] ST_SER  = 3'd3;
  localparam logic [2:0] ST_END  = 3'd4;

  localparam logic [2:0] SLOT_LAST = 3'd6;

  localparam logic [7:0] CHAR_LF    = 8'h0a;
  localparam logic [7:0] CHAR_CR    = 8'h0d;
  localparam logic [7:0] CHAR_ESC   = 8'h1b;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_UA    = 8'h41;
  localparam logic [7:0] CHAR_UD    = 8'h44;
  localparam logic [7:0] CHAR_UJ    = 8'h4a;
  localparam logic [7:0] CHAR_UQ    = 8'h51;
  localparam logic [7:0] CHAR_US    = 8'h53;
  localparam logic [7:0] CHAR_UW    = 8'h57;
  localparam logic [7:0] CHAR_UZ    = 8'h5a;
  localparam logic [7:0] CHAR_LA    = 8'h61;
  localparam logic [7:0] CHAR_LD    = 8'h64;
  localparam logic [7:0] CHAR_LJ    = 8'h6a;
  localparam logic [7:0] CHAR_LQ    = 8'h71;
  localparam logic [7:0] CHAR_LS    = 8'h73;
  localparam logic [7:0] CHAR_LW    = 8'h77;
  localparam logic [7:0] CHAR_LZ    = 8'h7a;
  localparam logic [7:0] CHAR_NUL   = 8'h00;

  // slot walk: bit 1 (jog) takes two slots, fire then enter
  function automatic logic [2:0] slot_bit(input logic [2:0] slot);
    logic [2:0] b;
    case (slot)
      3'd0:    b = 3'd0;
      3'd1:    b = 3'd1;
      3'd2:    b = 3'd1;
      3'd3:    b = 3'd2;
      3'd4:    b = 3'd3;
      3'd5:    b = 3'd4;
      default: b = 3'd5;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] slot_code(input logic [2:0] slot, input logic por,
                                           input kpq_codes_t c);
    logic [7:0] k;
    case (slot)
      3'd0:    k = por ? c.code_left  : c.code_down;
      3'd1:    k = c.code_fire;
      3'd2:    k = c.code_enter;
      3'd3:    k = por ? c.code_right : c.code_up;
      3'd4:    k = por ? c.code_down  : c.code_left;
      3'd5:    k = por ? c.code_use   : c.code_right;
      default: k = por ? c.code_up    : c.code_use;
    endcase
    return k;
  endfunction

  function automatic logic [7:0] serial_code(input logic [7:0] ch, input kpq_codes_t c);
    logic [7:0] k;
    case (ch) inside
      CHAR_CR, CHAR_LF:                   k = c.code_enter;
      CHAR_ESC, CHAR_LQ, CHAR_UQ:         k = c.code_escape;
      CHAR_LW, CHAR_UW:                   k = c.code_up;
      CHAR_LS, CHAR_US:                   k = c.code_down;
      CHAR_LA, CHAR_UA:                   k = c.code_left;
      CHAR_LD, CHAR_UD:                   k = c.code_right;
      CHAR_SPACE:                         k = c.code_use;
      CHAR_LJ, CHAR_UJ, CHAR_LZ, CHAR_UZ: k = c.code_fire;
      default:                            k = ch;
    endcase
    return k;
  endfunction

  logic [2:0]  state_q, state_d;
  logic [2:0]  slot_q, slot_d;
  kpq_item_t   item_q;
  kpq_codes_t  codes_q;
  logic [5:0]  prev_q, prev_d;
  logic        map_q, map_d;
  logic        held_q, held_d;
  logic        fired_q, fired_d;
  logic [31:0] start_q, start_d;

  logic [2:0]  bit_idx;
  logic [7:0]  key_map;
  logic [7:0]  ser_key;
  logic [5:0]  chord_mask;
  logic        chord_on;
  logic [31:0] elapsed;
  logic        chord_fire;
  logic        want;
  logic        advance;
  logic        accept;

  assign bit_idx    = slot_bit(slot_q);
  assign key_map    = slot_code(slot_q, map_q, codes_q);
  assign ser_key    = serial_code(item_q.key_byte, codes_q);
  assign chord_mask = map_q ? CHORD_PORTRAIT : CHORD_LANDSCAPE;
  assign chord_on   = (item_q.keys_down & chord_mask) == chord_mask;
  assign elapsed    = item_q.now_ms - start_q;
  assign chord_fire = chord_on && held_q && !fired_q && (elapsed >= KPQ_HOLD_MS);

  assign item_i.ready = (state_q == ST_IDLE);
  assign accept       = item_i.valid && item_i.ready;
  assign cfg_ready_o  = 1'b1;

  always_comb begin
    cmd_o = '0;
    want  = 1'b0;
    unique case (state_q)
      ST_REL: begin
        want      = prev_q[bit_idx];
        cmd_o.key = key_map;
      end
      ST_CHG: begin
        want          = item_q.keys_down[bit_idx] != prev_q[bit_idx];
        cmd_o.pressed = item_q.keys_down[bit_idx];
        cmd_o.key     = key_map;
      end
      ST_SER: begin
        want = 1'b1;
        if (item_q.op == OP_PUSH) begin
          cmd_o.pressed = item_q.push_pressed;
          cmd_o.key     = item_q.key_byte;
        end else begin
          cmd_o.pressed = (slot_q == 3'd0);
          cmd_o.key     = ser_key;
        end
      end
      ST_END: begin
        want         = 1'b1;
        cmd_o.is_end = 1'b1;
        cmd_o.pop    = (item_q.op == OP_POP);
        cmd_o.pulse  = (item_q.op == OP_SCAN) && chord_fire;
      end
      default: ;
    endcase
  end

  assign cmd_valid_o = want;
  assign advance     = !want || cmd_ready_i;

  always_comb begin
    state_d = state_q;
    slot_d  = slot_q;
    prev_d  = prev_q;
    map_d   = map_q;
    held_d  = held_q;
    fired_d = fired_q;
    start_d = start_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          slot_d = 3'd0;
          case (item_i.data.op)
            OP_SCAN:   state_d = (item_i.data.portrait != map_q) ? ST_REL : ST_CHG;
            OP_SERIAL: state_d = (item_i.data.key_byte != CHAR_NUL) ? ST_SER : ST_END;
            OP_PUSH:   state_d = ST_SER;
            default:   state_d = ST_END;
          endcase
        end
      end
      ST_REL: begin
        if (advance) begin
          if (slot_q == SLOT_LAST) begin
            // old map fully released, switch over
            prev_d  = '0;
            map_d   = item_q.portrait;
            slot_d  = 3'd0;
            state_d = ST_CHG;
          end else begin
            slot_d = slot_q + 3'd1;
          end
        end
      end
      ST_CHG: begin
        if (advance) begin
          if (slot_q == SLOT_LAST) begin
            prev_d  = item_q.keys_down;
            state_d = ST_END;
          end else begin
            slot_d = slot_q + 3'd1;
          end
        end
      end
      ST_SER: begin
        if (advance) begin
          if (item_q.op == OP_PUSH || slot_q != 3'd0) begin
            state_d = ST_END;
          end else begin
            slot_d = 3'd1;
          end
        end
      end
      ST_END: begin
        if (advance) begin
          state_d = ST_IDLE;
          if (item_q.op == OP_SCAN) begin
            if (chord_on) begin
              if (!held_q) begin
                held_d  = 1'b1;
                start_d = item_q.now_ms;
              end else if (chord_fire) begin
                fired_d = 1'b1;
              end
            end else begin
              held_d  = 1'b0;
              fired_d = 1'b0;
            end
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      slot_q  <= 3'd0;
      prev_q  <= '0;
      map_q   <= 1'b0;
      held_q  <= 1'b0;
      fired_q <= 1'b0;
      start_q <= '0;
      codes_q <= KPQ_CODES_RESET;
    end else begin
      state_q <= state_d;
      slot_q  <= slot_d;
      prev_q  <= prev_d;
      map_q   <= map_d;
      held_q  <= held_d;
      fired_q <= fired_d;
      start_q <= start_d;
      if (cfg_valid_i) begin
        unique case (kpq_reg_e'(cfg_index_i))
          REG_ENTER:  codes_q.code_enter  <= cfg_data_i;
          REG_ESCAPE: codes_q.code_escape <= cfg_data_i;
          REG_UP:     codes_q.code_up     <= cfg_data_i;
          REG_DOWN:   codes_q.code_down   <= cfg_data_i;
          REG_LEFT:   codes_q.code_left   <= cfg_data_i;
          REG_RIGHT:  codes_q.code_right  <= cfg_data_i;
          REG_USE:    codes_q.code_use    <= cfg_data_i;
          REG_FIRE:   codes_q.code_fire   <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_i.data;
    end
  end

  `KPQ_ASSERT(a_busy_after_accept, accept |=> !item_i.ready, "front took an item while busy")
  `KPQ_ASSERT(a_pulse_on_scan_end, (cmd_valid_o && cmd_o.pulse) |-> (cmd_o.is_end && item_q.op == OP_SCAN), "chord pulse outside a scan end")
  `KPQ_ASSERT(a_release_needs_turn, (state_q == ST_REL) |-> (map_q != item_q.portrait), "release pass without orientation change")

endmodule

@@ rtl/kpq_cmd_fifo.sv @@
module kpq_cmd_fifo import kpq_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  kpq_cmd_t cmd_i,
  input  logic     cmd_valid_i,
  output logic     cmd_ready_o,
  output kpq_cmd_t cmd_o,
  output logic     cmd_valid_o,
  input  logic     cmd_ready_i
);

  localparam int unsigned CNT_W = KPQ_CMDQ_PTR_W + 1;

  kpq_cmd_t                  entry_q [KPQ_CMDQ_DEPTH];
  logic [KPQ_CMDQ_PTR_W-1:0] wr_q;
  logic [KPQ_CMDQ_PTR_W-1:0] rd_q;
  logic [CNT_W-1:0]          cnt_q;
  logic                      push;
  logic                      pop;

  assign cmd_ready_o = cnt_q != CNT_W'(KPQ_CMDQ_DEPTH);
  assign cmd_valid_o = cnt_q != '0;
  assign cmd_o       = entry_q[rd_q];
  assign push        = cmd_valid_i && cmd_ready_o;
  assign pop         = cmd_valid_o && cmd_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= wr_q + 1'b1;
      if (pop)  rd_q <= rd_q + 1'b1;
      case ({push, pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) entry_q[wr_q] <= cmd_i;
  end

endmodule

@@ rtl/kpq_back.sv @@
`include "keypad_event_queue_unit_macros.svh"

module kpq_back import kpq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = KPQ_QUEUE_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  kpq_cmd_t   cmd_i,
  input  logic       cmd_valid_i,
  output logic       cmd_ready_o,
  kpq_result_if.source result_o
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = PTR_W + 1;

  logic [8:0]       store [QUEUE_DEPTH];
  logic [8:0]       rd_data_q;
  logic [PTR_W-1:0] wp_q, wp_d;
  logic [PTR_W-1:0] rp_q, rp_d;
  logic [PTR_W-1:0] wp_next;
  logic [PTR_W-1:0] rp_next;
  logic             pend_q, pend_d;
  logic             out_valid_q, out_valid_d;
  kpq_result_t      out_q, out_d;

  logic             full;
  logic             empty;
  logic             out_free;
  logic             take;
  logic             store_we;
  logic             rd_en;
  logic             load_end;
  logic             load_pend;
  logic [CNT_W-1:0] count;

  assign wp_next  = (wp_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wp_q + 1'b1;
  assign rp_next  = (rp_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rp_q + 1'b1;
  assign full     = wp_next == rp_q;
  assign empty    = wp_q == rp_q;
  assign out_free = !out_valid_q || result_o.ready;

  assign cmd_ready_o = !pend_q && (!cmd_i.is_end || out_free);
  assign take        = cmd_valid_i && cmd_ready_o;
  assign store_we    = take && !cmd_i.is_end && !full;
  assign rd_en       = take && cmd_i.is_end && cmd_i.pop && !empty;
  assign load_end    = take && cmd_i.is_end && !rd_en;
  assign load_pend   = pend_q && out_free;

  // entries held, modulo the ring depth
  assign count = {1'b0, wp_q} - {1'b0, rp_q} +
                 ((wp_q < rp_q) ? CNT_W'(QUEUE_DEPTH) : CNT_W'(0));

  always_comb begin
    wp_d        = wp_q;
    rp_d        = rp_q;
    pend_d      = pend_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_valid_q && result_o.ready) out_valid_d = 1'b0;
    if (store_we) wp_d = wp_next;
    if (rd_en) begin
      rp_d   = rp_next;
      pend_d = 1'b1;
    end
    if (load_end) begin
      out_valid_d       = 1'b1;
      out_d             = '0;
      out_d.pitch_toggle = cmd_i.pulse;
      out_d.queue_count  = 5'(count);
    end
    if (load_pend) begin
      pend_d              = 1'b0;
      out_valid_d         = 1'b1;
      out_d.event_valid   = 1'b1;
      out_d.event_pressed = rd_data_q[8];
      out_d.event_key     = rd_data_q[7:0];
      out_d.pitch_toggle  = 1'b0;
      out_d.queue_count   = 5'(count);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q        <= '0;
      rp_q        <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      wp_q        <= wp_d;
      rp_q        <= rp_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (store_we) store[wp_q] <= {cmd_i.pressed, cmd_i.key};
    if (rd_en)    rd_data_q <= store[rp_q];
  end

  assign result_o.valid = out_valid_q;
  assign result_o.data  = out_q;

  `KPQ_ASSERT(a_pend_blocks_cmds, pend_q |-> !cmd_ready_o, "command taken during pop read")
  `KPQ_ASSERT(a_write_not_empty, store_we |=> (wp_q != rp_q), "ring empty right after a write")
  `KPQ_ASSERT(a_pend_from_pop, $rose(pend_q) |-> $past(cmd_valid_i && cmd_i.pop), "pop read without a pop command")

endmodule

@@ rtl/keypad_event_queue_unit.sv @@
// keypad event queue
// item_i: one transfer per item (scan, serial character, raw key push or pop);
// result_o: exactly one result transfer per item, in item order.
// cfg_*: key code register writes, always ready; the user writes them only
// while idle, the block itself does not enforce it. the front walks a scan
// over seven key slots to release held keys when the orientation flips, then
// seven slots to queue changes; the jog key takes two slots (fire then enter).
// a serial character other than NUL sends a press and a release, a raw push
// one event; each item ends with an end marker, and the front takes a new
// item only once back in idle. a 4-entry command queue lets the front run
// ahead of the back, which writes one event per cycle into the ring store
// while no pop read is pending and performs pops through its registered read
// port; a pop result goes through the read data register, then the output
// register. results wait in an output register; a stalled receiver fills the
// command queue and then holds the front, nothing is lost.
// the ring holds QUEUE_DEPTH-1 events; pushes into a full ring are dropped.
// reset clears pointers, key history, chord state and the output valid flag
// and loads the default key codes; the event store needs no clearing.
module keypad_event_queue_unit import kpq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = KPQ_QUEUE_DEPTH
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  kpq_item_if.sink                 item_i,
  kpq_result_if.source             result_o,
  input  logic                     cfg_valid_i,
  input  logic [KPQ_REG_IDX_W-1:0] cfg_index_i,
  input  logic [7:0]               cfg_data_i,
  output logic                     cfg_ready_o
);

  // front to command queue
  kpq_cmd_t front_cmd;
  logic     front_valid;
  logic     front_ready;

  // command queue to back
  kpq_cmd_t back_cmd;
  logic     back_valid;
  logic     back_ready;

  // classifier and event sequencer
  kpq_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (item_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_ready_o (cfg_ready_o),
    .cmd_o       (front_cmd),
    .cmd_valid_o (front_valid),
    .cmd_ready_i (front_ready)
  );

  // decoupling queue
  kpq_cmd_fifo u_cmd_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (front_cmd),
    .cmd_valid_i (front_valid),
    .cmd_ready_o (front_ready),
    .cmd_o       (back_cmd),
    .cmd_valid_o (back_valid),
    .cmd_ready_i (back_ready)
  );

  // ring store, pops and result register
  kpq_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (back_cmd),
    .cmd_valid_i (back_valid),
    .cmd_ready_o (back_ready),
    .result_o    (result_o)
  );

endmodule
